[hdl/softmax_top_k_select_assert.svh]
// Assertion macros used by the top-level RTL file.
`ifndef SOFTMAX_TOP_K_SELECT_ASSERT_SVH
`define SOFTMAX_TOP_K_SELECT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SFTK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SFTK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFTK_ASSERT_IMP(label, ante, cons, msg)
`define SFTK_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[hdl/sftk_pkg.sv]
`default_nettype none
package sftk_pkg;

  localparam int CLASS_SLOTS = 1024;
  localparam int MAX_KEEP    = 64;
  localparam int ID_W        = 10;
  localparam int LOGIT_W     = 16;
  localparam int SCORE_W     = 18;
  localparam int KEEP_W      = 7;
  localparam int ADDR_W      = $clog2(CLASS_SLOTS);
  localparam int SEEN_W      = $clog2(CLASS_SLOTS + 1);
  localparam int FILL_W      = $clog2(MAX_KEEP + 1);
  localparam int E_W         = 17;
  localparam int SUM_W       = $clog2(CLASS_SLOTS) + E_W;
  localparam int NUM_W       = E_W + 16;
  localparam int EXP_BITS    = 12;

  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;

  typedef enum logic {
    CFG_SOFTMAX_ENABLE = 1'b0,
    CFG_KEEP_COUNT     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic                      valid;
    logic signed [LOGIT_W-1:0] logit;
    logic [ID_W-1:0]           id;
  } sftk_entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } sftk_chain_ctl_t;

  typedef logic [EXP_BITS-1:0][61:0] sftk_coef_t;

  function automatic logic [61:0] sftk_mul_q62(input logic [61:0] a, input logic [61:0] b);
    logic [125:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:62];
  endfunction

  function automatic sftk_coef_t sftk_build_coef();
    sftk_coef_t c;
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'h4000_0000_0000_0000;
    term = 64'h4000_0000_0000_0000;
    for (int k = 1; k < 20; k++) begin
      term = (term >> 8) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    c[0] = sum[61:0];
    for (int i = 1; i < EXP_BITS; i++) begin
      c[i] = sftk_mul_q62(c[i-1], c[i-1]);
    end
    return c;
  endfunction

  localparam sftk_coef_t EXP_COEF = sftk_build_coef();

endpackage
`default_nettype wire

[hdl/sftk_cell.sv]
`default_nettype none
module sftk_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  sftk_pkg::sftk_chain_ctl_t  ctl_i,
  input  sftk_pkg::sftk_entry_t      new_i,
  input  sftk_pkg::sftk_entry_t      prev_i,
  input  wire                        prev_beats_i,
  input  sftk_pkg::sftk_entry_t      next_i,
  output sftk_pkg::sftk_entry_t      entry_o,
  output logic                       beats_o
);
  import sftk_pkg::*;

  sftk_entry_t entry_r;

  // The new word ranks above this cell when the cell is empty or holds a smaller logit.
  assign beats_o = !entry_r.valid || (new_i.logit > entry_r.logit);
  assign entry_o = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (ctl_i.clear) begin
      entry_r.valid <= 1'b0;
    end else if (ctl_i.insert) begin
      if (beats_o) begin
        entry_r <= prev_beats_i ? prev_i : new_i;
      end
    end else if (ctl_i.shift) begin
      entry_r <= next_i;
    end
  end

endmodule
`default_nettype wire

[hdl/sftk_chain.sv]
`default_nettype none
module sftk_chain (
  input  wire                        clk,
  input  wire                        rst_n,
  input  sftk_pkg::sftk_chain_ctl_t  ctl_i,
  input  sftk_pkg::sftk_entry_t      new_i,
  output sftk_pkg::sftk_entry_t      head_o
);
  import sftk_pkg::*;

  sftk_entry_t ent   [MAX_KEEP];
  logic        beats [MAX_KEEP];

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    sftk_entry_t prev_e;
    sftk_entry_t next_e;
    logic        prev_b;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_b = beats[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end

    sftk_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl_i),
      .new_i        (new_i),
      .prev_i       (prev_e),
      .prev_beats_i (prev_b),
      .next_i       (next_e),
      .entry_o      (ent[i]),
      .beats_o      (beats[i])
    );
  end

  assign head_o = ent[0];

endmodule
`default_nettype wire

[hdl/sftk_exp.sv]
`default_nettype none
module sftk_exp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start_i,
  input  wire  [15:0]                  n_i,
  output logic                         done_o,
  output logic [sftk_pkg::E_W-1:0]     e_o
);
  import sftk_pkg::*;

  typedef enum logic [2:0] {E_IDLE, E_BIT, E_MUL, E_ACC, E_DONE} exp_state_t;

  exp_state_t             state_r;
  logic [EXP_BITS-1:0]    n_r;
  logic [3:0]             bit_r;
  logic [1:0]             phase_r;
  logic [62:0]            v_r;
  logic [125:0]           acc_r;
  logic [63:0]            pp_r;
  logic [1:0]             pp_sh_r;
  logic                   pp_vld_r;
  logic                   done_r;
  logic [E_W-1:0]         e_r;

  logic [61:0]  coef;
  logic [31:0]  va;
  logic [31:0]  cb;
  logic [1:0]   pp_sh;
  logic [125:0] pp_shifted;
  logic [125:0] acc_sum;
  logic [63:0]  rounded;
  logic         last_bit;

  assign coef     = EXP_COEF[bit_r];
  assign va       = phase_r[0] ? {1'b0, v_r[62:32]} : v_r[31:0];
  assign cb       = phase_r[1] ? {2'b0, coef[61:32]} : coef[31:0];
  assign pp_sh    = {1'b0, phase_r[0]} + {1'b0, phase_r[1]};
  assign last_bit = (bit_r == 4'(EXP_BITS - 1));
  assign rounded  = {1'b0, v_r} + 64'h0000_2000_0000_0000;

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = {62'd0, pp_r};
      2'd1:    pp_shifted = {30'd0, pp_r, 32'd0};
      2'd2:    pp_shifted = {pp_r[61:0], 64'd0};
      default: pp_shifted = '0;
    endcase
    acc_sum = acc_r + (pp_vld_r ? pp_shifted : 126'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        E_IDLE: begin
          if (start_i) begin
            if (|n_i[15:EXP_BITS]) begin
              e_r    <= '0;
              done_r <= 1'b1;
            end else begin
              n_r     <= n_i[EXP_BITS-1:0];
              v_r     <= ONE_Q62;
              bit_r   <= '0;
              state_r <= E_BIT;
            end
          end
        end
        E_BIT: begin
          if (n_r[bit_r]) begin
            phase_r  <= '0;
            acc_r    <= '0;
            pp_vld_r <= 1'b0;
            state_r  <= E_MUL;
          end else if (last_bit) begin
            state_r <= E_DONE;
          end else begin
            bit_r <= bit_r + 4'd1;
          end
        end
        E_MUL: begin
          pp_r     <= {32'd0, va} * {32'd0, cb};
          pp_sh_r  <= pp_sh;
          pp_vld_r <= 1'b1;
          acc_r    <= acc_sum;
          phase_r  <= phase_r + 2'd1;
          if (phase_r == 2'd3) begin
            state_r <= E_ACC;
          end
        end
        E_ACC: begin
          v_r <= {1'b0, acc_sum[123:62]};
          if (last_bit) begin
            state_r <= E_DONE;
          end else begin
            bit_r   <= bit_r + 4'd1;
            state_r <= E_BIT;
          end
        end
        E_DONE: begin
          e_r     <= rounded[62:46];
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign e_o    = e_r;

endmodule
`default_nettype wire

[hdl/sftk_div.sv]
`default_nettype none
module sftk_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start_i,
  input  wire  [sftk_pkg::NUM_W-1:0]   num_i,
  input  wire  [sftk_pkg::SUM_W-1:0]   den_i,
  output logic                         done_o,
  output logic [sftk_pkg::E_W-1:0]     q_o
);
  import sftk_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [5:0]         cnt_r;
  logic [SUM_W-1:0]   rem_r;
  logic [NUM_W-1:0]   quo_r;
  logic [SUM_W-1:0]   den_r;

  logic [SUM_W:0]     trial;
  logic [SUM_W:0]     diff;
  logic               ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= num_i;
        den_r  <= den_i;
      end
    end
  end

  assign done_o = done_r;
  assign q_o    = quo_r[E_W-1:0];

endmodule
`default_nettype wire

[hdl/softmax_top_k_select.sv]
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall   logit, final_class
// out_      output     out_valid / out_stall class_index, score, run_end, truncated
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// Logits are taken back to back while in_stall is low; the sorted row of cells ranks each
// stored logit on the accepting edge. After the final word, softmax mode sums the weights
// of all stored logits, read from the logit memory one at a time through the shared
// exponential unit. Each result then takes one exponential and a division; raw mode shows
// the head logit itself as the score. Reset is synchronous and active low.
// Input is stalled from the final word until the last result is taken.
`default_nettype none
`include "softmax_top_k_select_assert.svh"
module softmax_top_k_select (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [sftk_pkg::LOGIT_W-1:0]   in_logit,
  input  wire                                   in_final_class,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [sftk_pkg::ID_W-1:0]             out_class_index,
  output logic signed [sftk_pkg::SCORE_W-1:0]   out_score,
  output logic                                  out_run_end,
  output logic                                  out_truncated,
  input  wire                                   cfg_we,
  input  wire                                   cfg_index,
  input  wire  [sftk_pkg::KEEP_W-1:0]           cfg_data
);
  import sftk_pkg::*;

  typedef enum logic [2:0] {
    S_IN, S_SUM_RD, S_SUM_EXP, S_SUM_WAIT, S_EMIT, S_EXP_WAIT, S_DIV_WAIT, S_OUT
  } state_t;

  state_t                    state_r;
  logic                      softmax_en_r;
  logic [KEEP_W-1:0]         keep_r;
  logic [SEEN_W-1:0]         seen_r;
  logic signed [LOGIT_W-1:0] max_r;
  logic                      drop_r;
  logic [SEEN_W-1:0]         sum_idx_r;
  logic [SUM_W-1:0]          sum_r;
  logic [FILL_W-1:0]         remain_r;
  logic signed [LOGIT_W-1:0] rd_q_r;
  logic [LOGIT_W-1:0]        mem [CLASS_SLOTS];

  logic                      out_valid_r;
  logic [ID_W-1:0]           out_class_index_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic                      out_run_end_r;
  logic                      out_truncated_r;

  logic                      in_acc;
  logic                      out_acc;
  logic                      stored;
  logic [SEEN_W-1:0]         seen_upd;
  logic [FILL_W-1:0]         fill;
  logic [FILL_W-1:0]         k_sel;
  logic [FILL_W:0]           keep_ext;
  logic                      last_out;
  sftk_chain_ctl_t           ctl;
  sftk_entry_t               new_e;
  sftk_entry_t               head;
  logic signed [LOGIT_W:0]   diff_mem;
  logic signed [LOGIT_W:0]   diff_head;
  logic                      exp_start;
  logic [15:0]               exp_n;
  logic                      exp_done;
  logic [E_W-1:0]            exp_e;
  logic                      div_done;
  logic [E_W-1:0]            div_q;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign stored   = (seen_r < SEEN_W'(CLASS_SLOTS));
  assign seen_upd = stored ? seen_r + SEEN_W'(1) : seen_r;
  assign fill     = (seen_upd >= SEEN_W'(MAX_KEEP)) ? FILL_W'(MAX_KEEP) : FILL_W'(seen_upd);
  assign keep_ext = (FILL_W + 1)'(keep_r);
  assign k_sel    = ((keep_r == '0) || (keep_ext > {1'b0, fill})) ? fill : FILL_W'(keep_r);
  assign last_out = (remain_r == FILL_W'(1));

  assign ctl.insert = in_acc && stored;
  assign ctl.shift  = out_acc;
  assign ctl.clear  = out_acc && last_out;
  assign new_e.valid = 1'b1;
  assign new_e.logit = in_logit;
  assign new_e.id    = seen_r[ID_W-1:0];

  sftk_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl),
    .new_i  (new_e),
    .head_o (head)
  );

  assign diff_mem  = {max_r[LOGIT_W-1], max_r} - {rd_q_r[LOGIT_W-1], rd_q_r};
  assign diff_head = {max_r[LOGIT_W-1], max_r} - {head.logit[LOGIT_W-1], head.logit};
  assign exp_n     = (state_r == S_SUM_EXP) ? diff_mem[15:0] : diff_head[15:0];
  assign exp_start = (state_r == S_SUM_EXP) || ((state_r == S_EMIT) && softmax_en_r);

  sftk_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (exp_start),
    .n_i     (exp_n),
    .done_o  (exp_done),
    .e_o     (exp_e)
  );

  sftk_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i ((state_r == S_EXP_WAIT) && exp_done),
    .num_i   ({exp_e, 16'd0}),
    .den_i   (sum_r),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_ff @(posedge clk) begin
    if (in_acc && stored) begin
      mem[seen_r[ADDR_W-1:0]] <= in_logit;
    end
    rd_q_r <= mem[sum_idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      softmax_en_r <= 1'b0;
      keep_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SOFTMAX_ENABLE: softmax_en_r <= cfg_data[0];
        CFG_KEEP_COUNT:     keep_r       <= cfg_data;
        default:            keep_r       <= keep_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      seen_r      <= '0;
      max_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IN: begin
          if (in_acc) begin
            if (stored) begin
              seen_r <= seen_upd;
              if ((seen_r == '0) || (in_logit > max_r)) begin
                max_r <= in_logit;
              end
            end else begin
              drop_r <= 1'b1;
            end
            if (in_final_class) begin
              remain_r  <= k_sel;
              sum_idx_r <= '0;
              sum_r     <= '0;
              state_r   <= softmax_en_r ? S_SUM_RD : S_EMIT;
            end
          end
        end
        S_SUM_RD: state_r <= S_SUM_EXP;
        S_SUM_EXP: state_r <= S_SUM_WAIT;
        S_SUM_WAIT: begin
          if (exp_done) begin
            sum_r     <= sum_r + SUM_W'(exp_e);
            sum_idx_r <= sum_idx_r + SEEN_W'(1);
            state_r   <= (sum_idx_r + SEEN_W'(1) == seen_r) ? S_EMIT : S_SUM_RD;
          end
        end
        S_EMIT: begin
          if (softmax_en_r) begin
            state_r <= S_EXP_WAIT;
          end else begin
            out_valid_r       <= 1'b1;
            out_class_index_r <= head.id;
            out_score_r       <= SCORE_W'(head.logit);
            out_run_end_r     <= last_out;
            out_truncated_r   <= drop_r;
            state_r           <= S_OUT;
          end
        end
        S_EXP_WAIT: begin
          if (exp_done) begin
            state_r <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            out_valid_r       <= 1'b1;
            out_class_index_r <= head.id;
            out_score_r       <= {1'b0, div_q};
            out_run_end_r     <= last_out;
            out_truncated_r   <= drop_r;
            state_r           <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (last_out) begin
              seen_r  <= '0;
              max_r   <= '0;
              drop_r  <= 1'b0;
              state_r <= S_IN;
            end else begin
              remain_r <= remain_r - FILL_W'(1);
              state_r  <= S_EMIT;
            end
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IN);
  assign out_valid       = out_valid_r;
  assign out_class_index = out_class_index_r;
  assign out_score       = out_score_r;
  assign out_run_end     = out_run_end_r;
  assign out_truncated   = out_truncated_r;

  `SFTK_ASSERT_IMP(a_head_valid, out_valid_r, head.valid, "result shown without a ranked entry")
  `SFTK_ASSERT_IMP(a_exp_owner, exp_done,
    (state_r == S_SUM_WAIT) || (state_r == S_EXP_WAIT), "exponential result not awaited")
  `SFTK_ASSERT_NXT(a_frame_clear, out_acc && out_run_end_r,
    (seen_r == '0) && !head.valid, "frame state not cleared after last result")
  `SFTK_ASSERT_IMP(a_prob_range, out_valid_r && softmax_en_r,
    (out_score_r >= 0) && (out_score_r <= SCORE_W'(65536)), "probability out of range")

endmodule
`default_nettype wire

[dv/softmax_top_k_select_test.sv]
`default_nettype none
module softmax_top_k_select_test;
  import sftk_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [ID_W-1:0]           class_index;
    logic [SCORE_W-1:0]        score;
    logic                      run_end;
    logic                      truncated;
  } ranked_class_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [LOGIT_W-1:0] in_logit = '0;
  logic in_final_class = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ID_W-1:0] out_class_index;
  logic signed [SCORE_W-1:0] out_score;
  logic out_run_end;
  logic out_truncated;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [KEEP_W-1:0] cfg_data = '0;

  softmax_top_k_select DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_logit(in_logit),
    .in_final_class(in_final_class),
    .out_valid(out_valid), .out_stall(out_stall), .out_class_index(out_class_index),
    .out_score(out_score), .out_run_end(out_run_end), .out_truncated(out_truncated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ranked_class_t pending_results[$];
  logic signed [LOGIT_W-1:0] frame_logits[$];
  logic frame_dropped = 1'b0;
  logic mode_softmax = 1'b0;
  logic [KEEP_W-1:0] mode_keep = '0;
  logic [63:0] exp_coef[EXP_BITS];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("softmax_top_k_select_test NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] exp_weight(input int unsigned n);
    logic [63:0] v;
    v = 64'h4000_0000_0000_0000;
    if (n >= 4096) return 64'd0;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (n[i]) v = q62_mul(v, exp_coef[i]);
    end
    return (v + (64'd1 << 45)) >> 46;
  endfunction

  task automatic build_exp_coef();
    logic [63:0] acc;
    logic [63:0] term;
    acc = 64'h4000_0000_0000_0000;
    term = acc;
    for (int k = 1; k < 20; k++) begin
      term = (term >> 8) / 64'(k);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    exp_coef[0] = acc;
    for (int i = 1; i < EXP_BITS; i++) exp_coef[i] = q62_mul(exp_coef[i-1], exp_coef[i-1]);
  endtask

  // Ranks the stored frame and queues the classes the block should emit.
  task automatic close_frame();
    int seen;
    int k;
    int best;
    logic signed [LOGIT_W-1:0] fmax;
    logic [63:0] total;
    logic [63:0] e;
    bit taken[CLASS_SLOTS];
    ranked_class_t r;
    seen = frame_logits.size();
    k = mode_keep;
    if (k == 0 || k > seen) k = seen;
    if (k > MAX_KEEP) k = MAX_KEEP;
    fmax = frame_logits[0];
    foreach (frame_logits[i]) if (frame_logits[i] > fmax) fmax = frame_logits[i];
    total = 0;
    foreach (frame_logits[i]) begin
      total += exp_weight(int'(fmax) - int'(frame_logits[i]));
      taken[i] = 1'b0;
    end
    for (int rank = 0; rank < k; rank++) begin
      best = -1;
      foreach (frame_logits[i]) begin
        if (!taken[i] && (best < 0 || frame_logits[i] > frame_logits[best])) best = i;
      end
      taken[best] = 1'b1;
      r.class_index = best[ID_W-1:0];
      if (mode_softmax) begin
        e = exp_weight(int'(fmax) - int'(frame_logits[best]));
        r.score = SCORE_W'((e * 64'd65536) / total);
      end else begin
        r.score = SCORE_W'(frame_logits[best]);
      end
      r.run_end = (rank + 1 == k);
      r.truncated = frame_dropped;
      pending_results.push_back(r);
    end
    frame_logits.delete();
    frame_dropped = 1'b0;
  endtask

  task automatic send_word(input logic signed [LOGIT_W-1:0] logit, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_logit <= logit;
    in_final_class <= last;
    do @(posedge clk); while (in_stall);
    if (frame_logits.size() < CLASS_SLOTS) frame_logits.push_back(logit);
    else frame_dropped = 1'b1;
    if (last) close_frame();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic softmax, input logic [KEEP_W-1:0] keep);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SOFTMAX_ENABLE;
    cfg_data <= KEEP_W'(softmax);
    @(posedge clk);
    cfg_index <= CFG_KEEP_COUNT;
    cfg_data <= keep;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_softmax = softmax;
    mode_keep = keep;
  endtask

  task automatic send_frame(input int len, input int base, input int spread);
    for (int i = 0; i < len; i++) begin
      send_word(LOGIT_W'(base + $urandom_range(0, spread) - spread / 2), i == len - 1);
    end
  endtask

  task automatic test_raw_extremes();
    set_mode(1'b0, 7'd0);
    send_word(16'sh0000, 1'b0);
    send_word(-16'sd32768, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sd1, 1'b1);
    send_word(16'sh1234, 1'b1);
    drain();
  endtask

  task automatic test_keep_count();
    set_mode(1'b0, 7'd1);
    send_frame(4, 0, 200);
    drain();
    set_mode(1'b0, 7'd64);
    send_frame(5, 100, 20);
    drain();
    set_mode(1'b0, 7'd3);
    send_frame(2, 0, 4);
    drain();
  endtask

  task automatic test_softmax_extremes();
    set_mode(1'b1, 7'd0);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sd32768, 1'b0);
    send_word(16'sh7fff - 16'sd4095, 1'b0);
    send_word(16'sh7fff - 16'sd4096, 1'b0);
    send_word(16'sh7f00, 1'b1);
    send_word(-16'sd32768, 1'b1);
    drain();
  endtask

  task automatic test_frame_overflow();
    set_mode(1'b1, 7'd64);
    send_frame(CLASS_SLOTS + 6, 0, 3000);
    drain();
    set_mode(1'b0, 7'd0);
    send_frame(CLASS_SLOTS + 1, -5000, 60000);
    drain();
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    logic [KEEP_W-1:0] keep;
    sent = 0;
    while (sent < 370) begin
      case ($urandom_range(0, 3))
        0: keep = 7'd0;
        1: keep = 7'd64;
        default: keep = KEEP_W'($urandom_range(1, 64));
      endcase
      set_mode(1'($urandom), keep);
      for (int f = 0; f < 3; f++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 80) : $urandom_range(1, 20);
        if ($urandom_range(0, 1) != 0) send_frame(len, 0, 65535);
        else send_frame(len, int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 3000));
        sent += len;
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    ranked_class_t got;
    ranked_class_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_class_index, out_score, out_run_end, out_truncated};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
    case ((cycles / 300) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  initial begin
    build_exp_coef();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_raw_extremes();
    test_keep_count();
    test_softmax_extremes();
    test_frame_overflow();
    test_random_frames();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("softmax_top_k_select_test OK");
    end else begin
      $display("softmax_top_k_select_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
